// ===== src/bilinear_image_scaler_unit_defines.svh =====
// Assertion macros shared by the scaler's checker.
// No dependencies.
`ifndef BILINEAR_IMAGE_SCALER_UNIT_DEFINES_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_DEFINES_SVH
// Implication checked on every rising edge, muted while in reset.
`define BIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, muted while in reset.
`define BIS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/bis_pkg.sv =====
// Shared constants and types for the bilinear image scaler.
// No dependencies.
package bis_pkg;
	localparam int MAX_ROWS_DEF  = 256;
	localparam int MAX_COLS_DEF  = 256;
	localparam int FRAC_BITS_DEF = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 16;
	localparam int POS_W         = 10;
	localparam int STEP_W        = 16;
	localparam int SIZE_W        = 9;
	localparam int CH_W          = 8;
	localparam int PIX_W         = 3 * CH_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS     = 2'd0,
		REG_COLS     = 2'd1,
		REG_ROW_STEP = 2'd2,
		REG_COL_STEP = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		FUNC_WRITE   = 1'b0,
		FUNC_REQUEST = 1'b1
	} func_t;
endpackage

// ===== src/bis_bank.sv =====
// One bank of the frame store: a synchronous RAM with one write and one
// registered read port. Depends on bis_pkg.
module bis_bank #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [bis_pkg::PIX_W-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic [bis_pkg::PIX_W-1:0] rdata
);
	import bis_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== src/bilinear_image_scaler_unit.sv =====
// Top level of the bilinear image scaler: pipeline, frame store banks, config.
// Depends on bis_pkg and bis_bank.
//
// Usage: one item is taken per clock when start is high (busy stays low).
// func = write stores one 24-bit pixel at (pixel_row, pixel_col); writes off
// the store are dropped and give no result. func = request names an output
// pixel; one result follows on out_chan0..2 and edge_taken with done high
// for one cycle, once the item has passed the map multiply, address, bank read,
// weight multiply and sum/result register stages.
// Throughput: one item per clock, set by the four-bank frame store: pixels
// are banked by row and column parity, so the four neighbors of any position
// come out of four separate banks in one read.
// A write is visible to every request taken after it: the write port and the
// bank read sit in the same stage, so issue order is kept back to back.
// Config: cfg_we writes register cfg_idx with cfg_data while idle.
// Reset: arst_n clears control state and registers go to 256/256/1.25/1.25;
// pixel content is undefined until written. The receiver cannot stall.
module bilinear_image_scaler_unit #(
	parameter int MAX_ROWS  = bis_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = bis_pkg::MAX_COLS_DEF,
	parameter int FRAC_BITS = bis_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [bis_pkg::POS_W-1:0]      pixel_row,
	input  logic [bis_pkg::POS_W-1:0]      pixel_col,
	input  logic [bis_pkg::CH_W-1:0]       in_chan0,
	input  logic [bis_pkg::CH_W-1:0]       in_chan1,
	input  logic [bis_pkg::CH_W-1:0]       in_chan2,
	input  logic                           cfg_we,
	input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic [bis_pkg::CH_W-1:0]       out_chan0,
	output logic [bis_pkg::CH_W-1:0]       out_chan1,
	output logic [bis_pkg::CH_W-1:0]       out_chan2,
	output logic                           edge_taken
);
	import bis_pkg::*;

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CWD   = $clog2(MAX_COLS);
	localparam int RHW   = (RW > 1) ? RW - 1 : 1;
	localparam int CHW   = (CWD > 1) ? CWD - 1 : 1;
	localparam int BAW   = RHW + CHW;
	localparam int BDEP  = ((MAX_ROWS + 1) / 2) * (1 << CHW);
	localparam int PROD_W = POS_W + STEP_W;
	localparam int INT_W = PROD_W - FRAC_BITS;
	localparam int ONE_W = FRAC_BITS + 1;
	localparam int W_W   = 2 * FRAC_BITS + 2;
	localparam int ACC_W = CH_W + W_W + 2;
	localparam logic [ONE_W-1:0] ONE_FIX = ONE_W'(1) << FRAC_BITS;
	// size clamp limits, held to what the size registers can express
	localparam int SIZE_MAX = (1 << SIZE_W) - 1;
	localparam int MAXR_I = (MAX_ROWS > SIZE_MAX) ? SIZE_MAX : MAX_ROWS;
	localparam int MAXC_I = (MAX_COLS > SIZE_MAX) ? SIZE_MAX : MAX_COLS;
	localparam logic [SIZE_W:0] MAXR = (SIZE_W+1)'(MAXR_I);
	localparam logic [SIZE_W:0] MAXC = (SIZE_W+1)'(MAXC_I);
	// write bounds, held to what the position ports can express
	localparam int POS_LIM = 1 << POS_W;
	localparam logic [POS_W:0] WLIMR = (POS_W+1)'((MAX_ROWS > POS_LIM) ? POS_LIM : MAX_ROWS);
	localparam logic [POS_W:0] WLIMC = (POS_W+1)'((MAX_COLS > POS_LIM) ? POS_LIM : MAX_COLS);

	// config registers
	logic [SIZE_W-1:0] rows_q, cols_q;
	logic [STEP_W-1:0] rstep_q, cstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= SIZE_W'(256);
			cols_q  <= SIZE_W'(256);
			rstep_q <= STEP_W'(5120);
			cstep_q <= STEP_W'(5120);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ROWS:     rows_q  <= cfg_data[SIZE_W-1:0];
				REG_COLS:     cols_q  <= cfg_data[SIZE_W-1:0];
				REG_ROW_STEP: rstep_q <= cfg_data;
				REG_COL_STEP: cstep_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// last row/column in use after clamping
	logic [SIZE_W:0] rows_c, cols_c, lastr, lastc;
	always_comb begin
		rows_c = {1'b0, rows_q};
		cols_c = {1'b0, cols_q};
		if (rows_c == '0) rows_c = (SIZE_W+1)'(1);
		if (rows_c > MAXR) rows_c = MAXR;
		if (cols_c == '0) cols_c = (SIZE_W+1)'(1);
		if (cols_c > MAXC) cols_c = MAXC;
		lastr = rows_c - (SIZE_W+1)'(1);
		lastc = cols_c - (SIZE_W+1)'(1);
	end

	assign busy = 1'b0;
	logic acc;
	assign acc = start;

	// stage 1: map multiply, write item capture
	logic              v_s1, f_s1;
	logic [PROD_W-1:0] pr_s1, pc_s1;
	logic [POS_W-1:0]  wr_s1, wc_s1;
	logic [PIX_W-1:0]  wd_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		f_s1  <= func;
		pr_s1 <= PROD_W'(pixel_row) * PROD_W'(rstep_q);
		pc_s1 <= PROD_W'(pixel_col) * PROD_W'(cstep_q);
		wr_s1 <= pixel_row;
		wc_s1 <= pixel_col;
		wd_s1 <= {in_chan2, in_chan1, in_chan0};
	end

	// stage 2: edge test, neighbor addresses, write routing
	logic [INT_W-1:0] tr, tc;
	logic             edg;
	logic [RW-1:0]    r0, r1;
	logic [CWD-1:0]   c0, c1;
	always_comb begin
		tr  = pr_s1[PROD_W-1:FRAC_BITS];
		tc  = pc_s1[PROD_W-1:FRAC_BITS];
		edg = (tr >= INT_W'(lastr)) || (tc >= INT_W'(lastc));
		if (edg) begin
			r0 = RW'(lastr);  r1 = RW'(lastr);
			c0 = CWD'(lastc); c1 = CWD'(lastc);
		end else begin
			r0 = RW'(tr);  r1 = RW'(tr + INT_W'(1));
			c0 = CWD'(tc); c1 = CWD'(tc + INT_W'(1));
		end
	end

	logic                 v_s2, e_s2, we_s2;
	logic [FRAC_BITS-1:0] dr_s2, dc_s2;
	logic                 rp_s2, cp_s2;
	logic [BAW-1:0]       ra_s2 [4];
	logic [BAW-1:0]       wa_s2;
	logic [1:0]           wb_s2;
	logic [PIX_W-1:0]     wd_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0; we_s2 <= 1'b0;
		end else begin
			v_s2  <= v_s1 && f_s1;
			we_s2 <= v_s1 && !f_s1 && ({1'b0, wr_s1} < WLIMR)
				&& ({1'b0, wc_s1} < WLIMC);
		end
	end
	// bank b = {row parity, col parity}; address = {row/2, col/2}
	always_ff @(posedge clk) begin
		e_s2  <= edg;
		dr_s2 <= edg ? '0 : pr_s1[FRAC_BITS-1:0];
		dc_s2 <= edg ? '0 : pc_s1[FRAC_BITS-1:0];
		rp_s2 <= r0[0];
		cp_s2 <= c0[0];
		for (int b = 0; b < 4; b++) begin
			ra_s2[b] <= {RHW'((b[1] == r0[0] ? r0 : r1) >> 1),
				CHW'((b[0] == c0[0] ? c0 : c1) >> 1)};
		end
		wa_s2 <= {RHW'(wr_s1 >> 1), CHW'(wc_s1 >> 1)};
		wb_s2 <= {wr_s1[0], wc_s1[0]};
		wd_s2 <= wd_s1;
	end

	// stage 3: bank read (and pixel write)
	logic [PIX_W-1:0] rd [4];
	for (genvar g = 0; g < 4; g++) begin : g_bank
		bis_bank #(.DEPTH(BDEP), .AW(BAW)) u_bank (
			.clk  (clk),
			.we   (we_s2 && (wb_s2 == 2'(g))),
			.waddr(wa_s2),
			.wdata(wd_s2),
			.raddr(ra_s2[g]),
			.rdata(rd[g])
		);
	end

	logic                 v_s3, e_s3, rp_s3, cp_s3;
	logic [FRAC_BITS-1:0] dr_s3, dc_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		e_s3 <= e_s2; rp_s3 <= rp_s2; cp_s3 <= cp_s2;
		dr_s3 <= dr_s2; dc_s3 <= dc_s2;
	end

	// stage 4: weights and per-channel products
	// at an edge only the corner is used; the other banks read stray entries
	logic [PIX_W-1:0] p00, p01, p10, p11;
	logic [ONE_W-1:0] fr0, fr1, fc0, fc1;
	logic [W_W-1:0]   w00, w01, w10, w11;
	always_comb begin
		p00 = rd[{rp_s3, cp_s3}];
		p01 = e_s3 ? '0 : rd[{rp_s3, !cp_s3}];
		p10 = e_s3 ? '0 : rd[{!rp_s3, cp_s3}];
		p11 = e_s3 ? '0 : rd[{!rp_s3, !cp_s3}];
		fr1 = ONE_W'(dr_s3);
		fc1 = ONE_W'(dc_s3);
		fr0 = ONE_FIX - fr1;
		fc0 = ONE_FIX - fc1;
		w00 = W_W'(fr0) * W_W'(fc0);
		w01 = W_W'(fr0) * W_W'(fc1);
		w10 = W_W'(fr1) * W_W'(fc0);
		w11 = W_W'(fr1) * W_W'(fc1);
	end

	logic             v_s4, e_s4;
	logic [W_W-1:0]   w_s4 [4];
	logic [PIX_W-1:0] px_s4 [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		e_s4 <= e_s3;
		w_s4[0] <= w00; w_s4[1] <= w01; w_s4[2] <= w10; w_s4[3] <= w11;
		px_s4[0] <= p00; px_s4[1] <= p01; px_s4[2] <= p10; px_s4[3] <= p11;
	end

	// stage 5: blend and truncate per channel
	logic [ACC_W-1:0] sum [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = '0;
			for (int n = 0; n < 4; n++) begin
				sum[k] = sum[k] + ACC_W'(px_s4[n][k*CH_W +: CH_W]) * ACC_W'(w_s4[n]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= v_s4;
	end
	always_ff @(posedge clk) begin
		out_chan0  <= sum[0][2*FRAC_BITS +: CH_W];
		out_chan1  <= sum[1][2*FRAC_BITS +: CH_W];
		out_chan2  <= sum[2][2*FRAC_BITS +: CH_W];
		edge_taken <= e_s4;
	end
endmodule

// ===== src/bis_checker.sv =====
// Port-level checker for the bilinear image scaler, bound to the top level.
// Depends on bis_pkg and the defines header.
`include "bilinear_image_scaler_unit_defines.svh"
module bis_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic func,
	input logic done
);
	import bis_pkg::*;

	// a request gives a result
	`BIS_ASSERT_IMP(a_req_result, clk, arst_n, start && !busy && func == FUNC_REQUEST, ##5 done, "request lost")
	// a write gives no result
	`BIS_ASSERT_IMP(a_wr_silent, clk, arst_n, start && !busy && func == FUNC_WRITE, ##5 !done, "write gave a result")
	// every result traces back to a request
	`BIS_ASSERT_IMP(a_no_invent, clk, arst_n, done, $past(start && !busy && func == FUNC_REQUEST, 5), "invented result")
	// never busy out of reset
	`BIS_ASSERT_NXT(a_not_busy, clk, arst_n, 1'b1, !busy, "busy raised")
endmodule

bind bilinear_image_scaler_unit bis_checker u_bis_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func), .done(done)
);
